// ----- src/bfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and codes of the bitmap frame allocator: operation and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 32;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  // Frame numbers are carried with one bit of headroom over the address.
  localparam int FRM_W    = ADDR_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_FREE       = 2'd1,
    MODE_MARK_AVAIL = 2'd2,
    MODE_MARK_USED  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_OOM     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_HINT,
    PTR_FIRST,
    PTR_INC
  } ptr_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_INVALID,
    RES_OOM,
    RES_HIT
  } res_op_t;

  typedef struct packed {
    logic    load_req;
    logic    clr_step;
    ptr_op_t ptr_op;
    logic    mem_rd;
    logic    mem_wr;
    res_op_t res_op;
    logic    out_load;
  } bfa_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  free_ok;
    logic  range_empty;
    logic  hint_empty;
    logic  word_nonzero;
    logic  ptr_at_end;
    logic  ptr_at_last;
    logic  clr_last;
  } bfa_stat_t;

endpackage
`default_nettype wire

// ----- src/bfa_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: one beat carries an operation with its address and length.
// ----------------------------------------------------------------------------
interface bfa_req_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ADDR_W-1:0]   address;
  logic [LEN_W-1:0]    length;

  modport source (output valid, output mode, output address, output length, input ready);
  modport sink   (input valid, input mode, input address, input length, output ready);
endinterface
`default_nettype wire

// ----- src/bfa_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: one beat per request, with frame address and status.
// ----------------------------------------------------------------------------
interface bfa_rsp_if;
  import bfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   frame_address;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output frame_address, output status, input ready);
  modport sink   (input valid, input frame_address, input status, output ready);
endinterface
`default_nettype wire

// ----- src/bfa_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap memory, word pointer, lowest-free-word hint, range decode, word
// update logic and the result registers.
// ----------------------------------------------------------------------------
module bfa_datapath import bfa_pkg::*; #(
  parameter int NUM_FRAMES  = 32768,
  parameter int FRAME_BYTES = 4096,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [MODE_W-1:0]   in_mode,
  input  wire logic [ADDR_W-1:0]   in_address,
  input  wire logic [LEN_W-1:0]    in_length,
  input  wire bfa_cmd_t            cmd,
  output bfa_stat_t                stat,
  output logic [ADDR_W-1:0]        out_address,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int MAP_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HINT_W    = $clog2(MAP_WORDS + 1);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int FS        = $clog2(FRAME_BYTES);
  localparam longint unsigned REACH = 64'd1 << (ADDR_W - FS);
  localparam longint unsigned LIMIT =
    (longint'(NUM_FRAMES) < REACH) ? longint'(NUM_FRAMES) : REACH;
  localparam logic [FRM_W-1:0]  LIMIT_F    = FRM_W'(LIMIT);
  localparam logic [HINT_W-1:0] HINT_EMPTY = HINT_W'(MAP_WORDS);
  localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(MAP_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;

  mode_t             req_mode;
  logic [ADDR_W-1:0] req_address;
  logic [LEN_W-1:0]  req_length;

  logic [WIDX_W-1:0] ptr;
  logic [HINT_W-1:0] hint;
  logic [WIDX_W-1:0] clr_idx;

  logic [WIDX_W-1:0] first_word, last_word;
  logic [BIT_W-1:0]  first_bit, last_bit;

  status_t           wk_status;
  logic [ADDR_W-1:0] wk_address;

  // Range decode from the captured request.
  logic [FRM_W-1:0] first_f, end_b, last_f, last_c;
  logic             free_ok, range_empty;

  always_comb begin
    first_f     = FRM_W'(req_address >> FS);
    end_b       = {1'b0, req_address} + {1'b0, req_length} - FRM_W'(1);
    last_f      = end_b >> FS;
    last_c      = (last_f >= LIMIT_F) ? (LIMIT_F - FRM_W'(1)) : last_f;
    free_ok     = (req_address[FS-1:0] == '0) && (first_f < LIMIT_F);
    range_empty = (req_length == '0) || (first_f >= LIMIT_F);
  end

  // Word update.
  logic [BIT_W-1:0]     low_bit;
  logic [BIT_W-1:0]     lo, hi;
  logic [WORD_BITS-1:0] mask, wdata, onehot_free, onehot_low;
  logic                 word_nonzero, mem_we;
  logic [WIDX_W-1:0]    waddr;
  logic [HINT_W-1:0]    ptr_ext;

  always_comb begin
    low_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (rdata[i]) low_bit = BIT_W'(i);
    end
    word_nonzero = (rdata != '0);
    lo   = (ptr == first_word) ? first_bit : '0;
    hi   = (ptr == last_word) ? last_bit : '1;
    // Shifting all ones right by ~hi keeps bits 0..hi.
    mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));
    onehot_free = WORD_BITS'(1) << first_bit;
    onehot_low  = WORD_BITS'(1) << low_bit;
    case (req_mode)
      MODE_ALLOC:      wdata = rdata & ~onehot_low;
      MODE_FREE:       wdata = rdata | onehot_free;
      MODE_MARK_AVAIL: wdata = rdata | mask;
      default:         wdata = rdata & ~mask;
    endcase
    ptr_ext = HINT_W'(ptr);
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      waddr  = clr_idx;
      wdata  = '0;
    end else begin
      // A scanned word with no free frame is left alone.
      mem_we = cmd.mem_wr && !(req_mode == MODE_ALLOC && !word_nonzero);
      waddr  = ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode    <= mode_t'(in_mode);
      req_address <= in_address;
      req_length  <= in_length;
      wk_status   <= ST_OK;
      wk_address  <= '0;
    end
    first_word <= first_f[BIT_W +: WIDX_W];
    first_bit  <= first_f[BIT_W-1:0];
    last_word  <= last_c[BIT_W +: WIDX_W];
    last_bit   <= last_c[BIT_W-1:0];
    case (cmd.ptr_op)
      PTR_HINT:  ptr <= hint[WIDX_W-1:0];
      PTR_FIRST: ptr <= first_f[BIT_W +: WIDX_W];
      PTR_INC:   ptr <= ptr + WIDX_W'(1);
      default:   ptr <= ptr;
    endcase
    case (cmd.res_op)
      RES_INVALID: wk_status <= ST_INVALID;
      RES_OOM:     wk_status <= ST_OOM;
      RES_HIT:     wk_address <= ADDR_W'({ptr, low_bit}) << FS;
      default:     ;
    endcase
    if (cmd.out_load) begin
      out_address <= wk_address;
      out_status  <= wk_status;
    end
  end

  // The hint is a word index below which every word is known to be all used.
  always_ff @(posedge clk) begin
    if (rst) begin
      hint    <= HINT_EMPTY;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + WIDX_W'(1);
      if (cmd.mem_wr) begin
        case (req_mode)
          MODE_ALLOC:      hint <= word_nonzero ? ptr_ext : ptr_ext + HINT_W'(1);
          MODE_FREE,
          MODE_MARK_AVAIL: if (ptr_ext < hint) hint <= ptr_ext;
          default:         ;
        endcase
      end
    end
  end

  always_comb begin
    stat.mode         = req_mode;
    stat.free_ok      = free_ok;
    stat.range_empty  = range_empty;
    stat.hint_empty   = (hint == HINT_EMPTY);
    stat.word_nonzero = word_nonzero;
    stat.ptr_at_end   = (ptr == LAST_WORD);
    stat.ptr_at_last  = (ptr == last_word);
    stat.clr_last     = (clr_idx == LAST_WORD);
  end

endmodule
`default_nettype wire

// ----- src/bfa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller: clearing pass after reset, request decode, read-modify-write
// sequencing over bitmap words, and the output handshake.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire bfa_stat_t stat,
  output bfa_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RD,
    S_WR,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.res_op = RES_NONE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_ALLOC: begin
            if (stat.hint_empty) begin
              cmd.res_op = RES_OOM;
              state_next = S_DONE;
            end else begin
              cmd.ptr_op = PTR_HINT;
              state_next = S_RD;
            end
          end
          MODE_FREE: begin
            if (!stat.free_ok) begin
              cmd.res_op = RES_INVALID;
              state_next = S_DONE;
            end else begin
              cmd.ptr_op = PTR_FIRST;
              state_next = S_RD;
            end
          end
          default: begin
            if (stat.range_empty) begin
              state_next = S_DONE;
            end else begin
              cmd.ptr_op = PTR_FIRST;
              state_next = S_RD;
            end
          end
        endcase
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        unique case (stat.mode)
          MODE_ALLOC: begin
            if (stat.word_nonzero) begin
              cmd.res_op = RES_HIT;
              state_next = S_DONE;
            end else if (stat.ptr_at_end) begin
              cmd.res_op = RES_OOM;
              state_next = S_DONE;
            end else begin
              cmd.ptr_op = PTR_INC;
              state_next = S_RD;
            end
          end
          MODE_FREE: state_next = S_DONE;
          default: begin
            if (stat.ptr_at_last) begin
              state_next = S_DONE;
            end else begin
              cmd.ptr_op = PTR_INC;
              state_next = S_RD;
            end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == S_IDLE);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- src/bitmap_frame_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// After a request is accepted it is decoded, and each bitmap word that it touches is
// read and then written back. A valid free touches one word. A range touches
// each word it covers, and an allocate scans words upward from the lowest-free-word hint.
// A rejected free, a zero-length range or a map known to be full goes straight to the response.
// Throughput: one request at a time; ready returns in the same cycle as the response's valid.
// Reset: a clearing pass over all MAP_WORDS bitmap words marks every frame used first.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit import bfa_pkg::*; #(
  parameter int NUM_FRAMES  = 32768,
  parameter int FRAME_BYTES = 4096,
  parameter int WORD_BITS   = 32
) (
  input wire logic clk,
  input wire logic rst,
  bfa_req_if.sink  req,
  bfa_rsp_if.source rsp
);

  bfa_cmd_t  cmd;
  bfa_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfa_datapath #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES),
    .WORD_BITS   (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_mode     (req.mode),
    .in_address  (req.address),
    .in_length   (req.length),
    .cmd         (cmd),
    .stat        (stat),
    .out_address (rsp.frame_address),
    .out_status  (rsp.status)
  );

  // Only one request is in flight: ready drops right after an accepted beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.mem_rd, cmd.mem_wr, cmd.clr_step}))
    else $error("bitmap memory port used twice in one cycle");

  a_oom_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> rsp.frame_address == '0)
    else $error("nonzero frame address with error status");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_req |-> !cmd.out_load && !cmd.clr_step)
    else $error("request load overlaps result load or clearing");

endmodule
`default_nettype wire
